[hdl/h4df_pkg.sv]
`default_nettype none
package h4df_pkg;

    localparam int ByteW = 8;
    localparam int KindW = 2;
    localparam int LenW  = 16;
    localparam int IdxW  = 3;

    localparam logic [ByteW-1:0] TYPE_ACL   = 8'h02;
    localparam logic [ByteW-1:0] TYPE_SCO   = 8'h03;
    localparam logic [ByteW-1:0] TYPE_EVENT = 8'h04;

    localparam logic [KindW-1:0] KIND_EVENT = 2'd0;
    localparam logic [KindW-1:0] KIND_ACL   = 2'd1;
    localparam logic [KindW-1:0] KIND_SCO   = 2'd2;

    // header length per kind, type byte excluded
    localparam logic [IdxW:0] HDR_EVENT = 4'd2;
    localparam logic [IdxW:0] HDR_ACL   = 4'd4;
    localparam logic [IdxW:0] HDR_SCO   = 4'd3;

    localparam logic [IdxW-1:0] IDX_EVT_LEN = 3'd1;
    localparam logic [IdxW-1:0] IDX_SCO_LEN = 3'd2;
    localparam logic [IdxW-1:0] IDX_ACL_LO  = 3'd2;
    localparam logic [IdxW-1:0] IDX_ACL_HI  = 3'd3;

    typedef enum logic [2:0] {
        PH_TYPE    = 3'b001,
        PH_HEADER  = 3'b010,
        PH_PAYLOAD = 3'b100
    } phase_t;

    typedef struct packed {
        logic             valid;
        logic [ByteW-1:0] data;
    } beat_t;

endpackage
`default_nettype wire

[hdl/hci_h4_packet_deframer_unit.sv]
`default_nettype none
// HCI H4 deframer: takes one byte of the H4 stream per beat on rx_* and gives out every
// header and payload byte after the type byte on out_*, tagged with the packet kind
// (0 event, 1 ACL, 2 SCO) and a last mark on the frame's final byte. Valid type bytes give
// no output beat; an unknown type byte comes out once with dropped set and the next byte
// is taken as a new type byte. Throughput is one byte per cycle unless out_stall holds
// the output; a byte passes the input holding register, then the frame state machine
// into the output register. No clearing pass after reset.
module hci_h4_packet_deframer_unit (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       rx_valid,
    output logic                            rx_stall,
    input  wire logic [h4df_pkg::ByteW-1:0] rx_byte,
    output logic                            out_valid,
    input  wire logic                       out_stall,
    output logic [h4df_pkg::ByteW-1:0]      data_byte,
    output logic [h4df_pkg::KindW-1:0]      pkt_kind,
    output logic                            last,
    output logic                            dropped
);

    h4df_pkg::beat_t beat;
    logic            take;

    h4df_in_stage u_in (
        .clk      (clk),
        .rst_n    (rst_n),
        .rx_valid (rx_valid),
        .rx_byte  (rx_byte),
        .rx_stall (rx_stall),
        .take     (take),
        .beat     (beat)
    );

    h4df_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .beat      (beat),
        .take      (take),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .data_byte (data_byte),
        .pkt_kind  (pkt_kind),
        .last      (last),
        .dropped   (dropped)
    );

endmodule
`default_nettype wire

[hdl/h4df_in_stage.sv]
`default_nettype none
module h4df_in_stage (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   rx_valid,
    input  wire logic [h4df_pkg::ByteW-1:0] rx_byte,
    output logic                        rx_stall,
    input  wire logic                   take,
    output h4df_pkg::beat_t             beat
);

    logic                        valid_reg;
    logic                        valid_next;
    logic [h4df_pkg::ByteW-1:0]  data_reg;
    logic                        accept;

    // holding register may refill in the same cycle it drains
    assign rx_stall   = valid_reg && !take;
    assign accept     = rx_valid && !rx_stall;
    assign valid_next = accept ? 1'b1 : (take ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            data_reg <= rx_byte;
        end
    end

    assign beat.valid = valid_reg;
    assign beat.data  = data_reg;

endmodule
`default_nettype wire

[hdl/h4df_parser.sv]
`default_nettype none
module h4df_parser (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire h4df_pkg::beat_t            beat,
    output logic                            take,
    output logic                            out_valid,
    input  wire logic                       out_stall,
    output logic [h4df_pkg::ByteW-1:0]      data_byte,
    output logic [h4df_pkg::KindW-1:0]      pkt_kind,
    output logic                            last,
    output logic                            dropped
);

    h4df_pkg::phase_t              phase_reg, phase_next;
    logic [h4df_pkg::KindW-1:0]    kind_reg, kind_next;
    logic [h4df_pkg::IdxW-1:0]     idx_reg, idx_next;
    logic [h4df_pkg::ByteW-1:0]    len_lo_reg, len_lo_next;
    logic [h4df_pkg::LenW-1:0]     left_reg, left_next;

    logic                          ov_reg, ov_next;
    logic [h4df_pkg::ByteW-1:0]    data_reg, data_next;
    logic [h4df_pkg::KindW-1:0]    okind_reg, okind_next;
    logic                          last_reg, last_next;
    logic                          drop_reg, drop_next;

    logic                          go;
    logic                          emit;
    logic [h4df_pkg::IdxW:0]       hdr_len;
    logic [h4df_pkg::IdxW:0]       idx_inc;
    logic [h4df_pkg::KindW-1:0]    kind_eff;
    logic [h4df_pkg::ByteW-1:0]    b;

    assign take = !ov_reg || !out_stall;
    assign go   = beat.valid && take;
    assign b    = beat.data;

    assign kind_eff = (kind_reg == h4df_pkg::KIND_ACL || kind_reg == h4df_pkg::KIND_SCO)
                      ? kind_reg : h4df_pkg::KIND_EVENT;
    assign idx_inc  = {1'b0, idx_reg} + 4'd1;

    always_comb
    begin
        case (kind_eff)
            h4df_pkg::KIND_ACL: hdr_len = h4df_pkg::HDR_ACL;
            h4df_pkg::KIND_SCO: hdr_len = h4df_pkg::HDR_SCO;
            default:            hdr_len = h4df_pkg::HDR_EVENT;
        endcase
    end

    always_comb
    begin
        phase_next  = phase_reg;
        kind_next   = kind_reg;
        idx_next    = idx_reg;
        len_lo_next = len_lo_reg;
        left_next   = left_reg;
        emit        = 1'b0;
        data_next   = b;
        okind_next  = kind_eff;
        last_next   = 1'b0;
        drop_next   = 1'b0;

        case (phase_reg)
            h4df_pkg::PH_HEADER:
            begin
                emit = 1'b1;
                case (kind_eff)
                    h4df_pkg::KIND_ACL:
                    begin
                        if (idx_reg == h4df_pkg::IDX_ACL_LO)
                        begin
                            len_lo_next = b;
                        end
                        else if (idx_reg == h4df_pkg::IDX_ACL_HI)
                        begin
                            left_next = {b, len_lo_reg};
                        end
                    end
                    h4df_pkg::KIND_SCO:
                    begin
                        if (idx_reg == h4df_pkg::IDX_SCO_LEN)
                        begin
                            left_next = {{(h4df_pkg::LenW-h4df_pkg::ByteW){1'b0}}, b};
                        end
                    end
                    default:
                    begin
                        if (idx_reg == h4df_pkg::IDX_EVT_LEN)
                        begin
                            left_next = {{(h4df_pkg::LenW-h4df_pkg::ByteW){1'b0}}, b};
                        end
                    end
                endcase
                idx_next = idx_inc[h4df_pkg::IdxW-1:0];
                if (idx_inc >= hdr_len)
                begin
                    if (left_next == '0)
                    begin
                        last_next  = 1'b1;
                        phase_next = h4df_pkg::PH_TYPE;
                    end
                    else
                    begin
                        phase_next = h4df_pkg::PH_PAYLOAD;
                    end
                end
            end
            h4df_pkg::PH_PAYLOAD:
            begin
                emit      = 1'b1;
                left_next = left_reg - 16'd1;
                if (left_next == '0)
                begin
                    last_next  = 1'b1;
                    phase_next = h4df_pkg::PH_TYPE;
                end
            end
            default:
            begin
                idx_next    = '0;
                len_lo_next = '0;
                left_next   = '0;
                case (b)
                    h4df_pkg::TYPE_EVENT:
                    begin
                        kind_next  = h4df_pkg::KIND_EVENT;
                        phase_next = h4df_pkg::PH_HEADER;
                    end
                    h4df_pkg::TYPE_ACL:
                    begin
                        kind_next  = h4df_pkg::KIND_ACL;
                        phase_next = h4df_pkg::PH_HEADER;
                    end
                    h4df_pkg::TYPE_SCO:
                    begin
                        kind_next  = h4df_pkg::KIND_SCO;
                        phase_next = h4df_pkg::PH_HEADER;
                    end
                    default:
                    begin
                        // unknown type: flag it and resync on the next byte
                        emit       = 1'b1;
                        okind_next = h4df_pkg::KIND_EVENT;
                        drop_next  = 1'b1;
                        phase_next = h4df_pkg::PH_TYPE;
                    end
                endcase
            end
        endcase
    end

    assign ov_next = go ? emit : (take ? 1'b0 : ov_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= h4df_pkg::PH_TYPE;
            kind_reg   <= h4df_pkg::KIND_EVENT;
            idx_reg    <= '0;
            len_lo_reg <= '0;
            left_reg   <= '0;
            ov_reg     <= 1'b0;
        end
        else
        begin
            ov_reg <= ov_next;
            if (go)
            begin
                phase_reg  <= phase_next;
                kind_reg   <= kind_next;
                idx_reg    <= idx_next;
                len_lo_reg <= len_lo_next;
                left_reg   <= left_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (go && emit)
        begin
            data_reg  <= data_next;
            okind_reg <= okind_next;
            last_reg  <= last_next;
            drop_reg  <= drop_next;
        end
    end

    assign out_valid = ov_reg;
    assign data_byte = data_reg;
    assign pkt_kind  = okind_reg;
    assign last      = last_reg;
    assign dropped   = drop_reg;

endmodule
`default_nettype wire

[sim/tb.sv]
`default_nettype none
module tb;

    localparam int HOLD_CYCLES = 300;
    localparam int STALL_LIMIT = 4000;
    localparam int DRAIN_CYCLES = 20;

    typedef logic [h4df_pkg::ByteW-1:0] byte_t;
    typedef logic [h4df_pkg::LenW-1:0]  len_t;

    typedef struct {
        logic [h4df_pkg::ByteW-1:0] data;
        logic [h4df_pkg::KindW-1:0] kind;
        logic                       eof;
        logic                       drop;
    } frame_beat_t;

    logic                       clk;
    logic                       rst_n;
    logic                       rx_valid;
    logic                       rx_stall;
    logic [h4df_pkg::ByteW-1:0] rx_byte;
    logic                       out_valid;
    logic                       out_stall;
    logic [h4df_pkg::ByteW-1:0] data_byte;
    logic [h4df_pkg::KindW-1:0] pkt_kind;
    logic                       last;
    logic                       dropped;

    hci_h4_packet_deframer_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .rx_valid  (rx_valid),
        .rx_stall  (rx_stall),
        .rx_byte   (rx_byte),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .data_byte (data_byte),
        .pkt_kind  (pkt_kind),
        .last      (last),
        .dropped   (dropped)
    );

    // deframer state as predicted
    h4df_pkg::phase_t           ph;
    logic [h4df_pkg::KindW-1:0] cur_kind;
    logic [h4df_pkg::IdxW-1:0]  hdr_idx;
    logic [h4df_pkg::ByteW-1:0] len_lo;
    logic [h4df_pkg::LenW-1:0]  pay_left;

    frame_beat_t beats_due[$];

    int unsigned src_idle_pct;
    int unsigned sink_idle_pct;
    bit          hold_req;
    int unsigned n_bytes_in;
    int unsigned n_beats_out;
    int unsigned n_frames;
    int unsigned n_drops;
    int unsigned n_rx_stalls;
    int unsigned n_errors;
    int unsigned quiet_cycles = 0;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic void predict_byte(input logic [h4df_pkg::ByteW-1:0] b);
        logic [h4df_pkg::IdxW:0] hdr_len;
        frame_beat_t             e;
        bit                      emits;
        e.data = b;
        e.kind = cur_kind;
        e.eof  = 1'b0;
        e.drop = 1'b0;
        emits  = 1'b1;
        case (ph)
            h4df_pkg::PH_HEADER:
            begin
                hdr_len = (cur_kind == h4df_pkg::KIND_ACL) ? h4df_pkg::HDR_ACL :
                          (cur_kind == h4df_pkg::KIND_SCO) ? h4df_pkg::HDR_SCO :
                          h4df_pkg::HDR_EVENT;
                if (cur_kind == h4df_pkg::KIND_ACL)
                begin
                    if (hdr_idx == h4df_pkg::IDX_ACL_LO)
                        len_lo = b;
                    else if (hdr_idx == h4df_pkg::IDX_ACL_HI)
                        pay_left = {b, len_lo};
                end
                else if (cur_kind == h4df_pkg::KIND_SCO)
                begin
                    if (hdr_idx == h4df_pkg::IDX_SCO_LEN)
                        pay_left = {8'h00, b};
                end
                else if (hdr_idx == h4df_pkg::IDX_EVT_LEN)
                begin
                    pay_left = {8'h00, b};
                end
                if ({1'b0, hdr_idx} + 4'd1 >= hdr_len)
                begin
                    if (pay_left == '0)
                    begin
                        e.eof = 1'b1;
                        ph    = h4df_pkg::PH_TYPE;
                    end
                    else
                    begin
                        ph = h4df_pkg::PH_PAYLOAD;
                    end
                end
                hdr_idx = hdr_idx + 1'b1;
            end
            h4df_pkg::PH_PAYLOAD:
            begin
                pay_left = pay_left - 1'b1;
                if (pay_left == '0)
                begin
                    e.eof = 1'b1;
                    ph    = h4df_pkg::PH_TYPE;
                end
            end
            default:
            begin
                hdr_idx  = '0;
                len_lo   = '0;
                pay_left = '0;
                emits    = 1'b0;
                ph       = h4df_pkg::PH_HEADER;
                if (b == h4df_pkg::TYPE_EVENT)
                    cur_kind = h4df_pkg::KIND_EVENT;
                else if (b == h4df_pkg::TYPE_ACL)
                    cur_kind = h4df_pkg::KIND_ACL;
                else if (b == h4df_pkg::TYPE_SCO)
                    cur_kind = h4df_pkg::KIND_SCO;
                else
                begin
                    ph     = h4df_pkg::PH_TYPE;
                    emits  = 1'b1;
                    e.kind = h4df_pkg::KIND_EVENT;
                    e.drop = 1'b1;
                end
            end
        endcase
        if (emits)
            beats_due.push_back(e);
    endfunction

    // one beat on the input; prediction happens at the accepting edge
    task automatic send_byte(input logic [h4df_pkg::ByteW-1:0] b);
        @(negedge clk);
        while ($urandom_range(99) < src_idle_pct)
        begin
            rx_valid <= 1'b0;
            @(negedge clk);
        end
        rx_valid <= 1'b1;
        rx_byte  <= b;
        @(posedge clk);
        while (rx_stall)
        begin
            n_rx_stalls++;
            @(posedge clk);
        end
        predict_byte(b);
        n_bytes_in++;
    endtask

    task automatic send_frame(input logic [h4df_pkg::KindW-1:0] kind,
                              input logic [h4df_pkg::LenW-1:0] len);
        case (kind)
            h4df_pkg::KIND_ACL:
            begin
                send_byte(h4df_pkg::TYPE_ACL);
                send_byte(byte_t'($urandom_range(255)));
                send_byte(byte_t'($urandom_range(255)));
                send_byte(len[7:0]);
                send_byte(len[15:8]);
            end
            h4df_pkg::KIND_SCO:
            begin
                send_byte(h4df_pkg::TYPE_SCO);
                send_byte(byte_t'($urandom_range(255)));
                send_byte(byte_t'($urandom_range(255)));
                send_byte(len[7:0]);
            end
            default:
            begin
                send_byte(h4df_pkg::TYPE_EVENT);
                send_byte(byte_t'($urandom_range(255)));
                send_byte(len[7:0]);
            end
        endcase
        repeat (len) send_byte(byte_t'($urandom_range(255)));
    endtask

    function automatic logic [h4df_pkg::ByteW-1:0] junk_byte();
        logic [h4df_pkg::ByteW-1:0] b;
        do
            b = byte_t'($urandom_range(255));
        while (b inside {h4df_pkg::TYPE_ACL, h4df_pkg::TYPE_SCO, h4df_pkg::TYPE_EVENT});
        return b;
    endfunction

    function automatic logic [h4df_pkg::KindW-1:0] pick_kind();
        case ($urandom_range(2))
            0:       return h4df_pkg::KIND_EVENT;
            1:       return h4df_pkg::KIND_ACL;
            default: return h4df_pkg::KIND_SCO;
        endcase
    endfunction

    function automatic logic [h4df_pkg::LenW-1:0] pick_len();
        if ($urandom_range(99) < 85)
            return len_t'($urandom_range(6));
        return len_t'($urandom_range(64, 7));
    endfunction

    task automatic send_mix(input int unsigned n);
        int unsigned stop_at;
        stop_at = n_bytes_in + n;
        while (n_bytes_in < stop_at)
        begin
            if ($urandom_range(99) < 10)
                send_byte(junk_byte());
            else
                send_frame(pick_kind(), pick_len());
        end
    endtask

    task automatic test_directed();
        logic [h4df_pkg::ByteW-1:0] seq[] = '{
            h4df_pkg::TYPE_EVENT, 8'h0E, 8'h00,                 // empty event
            h4df_pkg::TYPE_ACL, 8'hFF, 8'hFF, 8'h00, 8'h00,     // empty ACL
            h4df_pkg::TYPE_SCO, 8'h00, 8'h00, 8'h01, 8'hFF,     // one-byte SCO
            8'h00, 8'hFF, 8'h01, 8'h05,                         // unknown type bytes
            h4df_pkg::TYPE_ACL, 8'h2A, 8'h20, 8'h02, 8'h00,
            h4df_pkg::TYPE_EVENT, h4df_pkg::TYPE_ACL
        };
        foreach (seq[i])
            send_byte(seq[i]);
    endtask

    task automatic test_random_stream();
        send_mix(150);
    endtask

    task automatic test_no_idle();
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        send_mix(80);
        src_idle_pct  = 15;
        sink_idle_pct = 15;
    endtask

    // lengths past one byte in the ACL high byte, and full 8-bit lengths
    task automatic test_long_frames();
        send_frame(h4df_pkg::KIND_ACL, len_t'($urandom_range(270, 256)));
        send_frame(h4df_pkg::KIND_EVENT, 16'd255);
        send_frame(h4df_pkg::KIND_SCO, 16'd255);
    endtask

    task automatic test_backpressure();
        src_idle_pct = 0;
        hold_req     = 1'b1;
        send_mix(60);
        src_idle_pct = 15;
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            n_beats_out++;
            if (beats_due.size() == 0)
            begin
                $error("output beat with nothing expected: data_byte %h", data_byte);
                n_errors++;
            end
            else
            begin
                if (data_byte !== beats_due[0].data)
                begin
                    $error("data_byte: expected %h, got %h", beats_due[0].data, data_byte);
                    n_errors++;
                end
                if (pkt_kind !== beats_due[0].kind)
                begin
                    $error("pkt_kind: expected %0d, got %0d", beats_due[0].kind, pkt_kind);
                    n_errors++;
                end
                if (last !== beats_due[0].eof)
                begin
                    $error("last: expected %b, got %b", beats_due[0].eof, last);
                    n_errors++;
                end
                if (dropped !== beats_due[0].drop)
                begin
                    $error("dropped: expected %b, got %b", beats_due[0].drop, dropped);
                    n_errors++;
                end
                if (beats_due[0].eof)
                    n_frames++;
                if (beats_due[0].drop)
                    n_drops++;
                void'(beats_due.pop_front());
            end
        end
    end

    // output side: random stall, or one long hold-off on request
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
                hold_req = 1'b0;
            end
            else
            begin
                out_stall <= ($urandom_range(99) < sink_idle_pct);
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (rx_valid && !rx_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("tb: timeout, %0d beats still expected", beats_due.size());
            $display("tb: FAIL");
            $finish;
        end
    end

    initial
    begin
        rst_n         = 1'b0;
        rx_valid      = 1'b0;
        rx_byte       = '0;
        src_idle_pct  = 15;
        sink_idle_pct = 15;
        hold_req      = 1'b0;
        n_bytes_in    = 0;
        n_beats_out   = 0;
        n_frames      = 0;
        n_drops       = 0;
        n_rx_stalls   = 0;
        n_errors      = 0;
        ph            = h4df_pkg::PH_TYPE;
        cur_kind      = h4df_pkg::KIND_EVENT;
        hdr_idx       = '0;
        len_lo        = '0;
        pay_left      = '0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_random_stream();
        test_no_idle();
        test_long_frames();
        test_backpressure();
        send_mix(40);

        @(negedge clk);
        rx_valid <= 1'b0;
        while (beats_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("tb: %0d bytes in, %0d beats out: %0d frames, %0d unknown type bytes",
                 n_bytes_in, n_beats_out, n_frames, n_drops);
        $display("tb: event/ACL/SCO frames incl. empty and long ones, %0d input stall cycles",
                 n_rx_stalls);
        if (n_errors == 0 && beats_due.size() == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end
endmodule
`default_nettype wire

[sim.f]
hdl/h4df_pkg.sv
hdl/h4df_in_stage.sv
hdl/h4df_parser.sv
hdl/hci_h4_packet_deframer_unit.sv
sim/tb.sv
